// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCXD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCXD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pcxd_pkg.sv =====
// shared widths, register indexes, types and packing functions of the pcx decoder
package pcxd_pkg;

   localparam int CODE_W     = 8;
   localparam int WORD_W     = 32;
   localparam int BC_W       = 3;
   localparam int RUN_W      = 6;
   localparam int GROUP_W    = 6;
   localparam int PLB_W      = 7;
   localparam int GW_W       = 9;
   localparam int LINES_W    = 10;
   localparam int COUNT_W    = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_LINE_BYTES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_WIDTH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_COUNT       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_COUNT     = 3'd4;

   localparam logic [CODE_W-1:0] RUN_BASE = 8'd192;
   localparam logic [GW_W-1:0]   GW_MAX   = 9'd256;

   typedef struct packed {
      logic              en;
      logic [CODE_W-1:0] data;
   } store_wr_type;

   // four plane bytes (plane p in byte p) to four packed nibble-pair bytes, or two when four is clear
   function automatic logic [WORD_W-1:0] pack_group(input logic [WORD_W-1:0] planes,
                                                    input logic four);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int m = 0; m < 4; m++) begin
         for (int p = 0; p < 4; p++) begin
            w[8*m + p]     = planes[8*p + 7 - 2*m];
            w[8*m + 4 + p] = planes[8*p + 6 - 2*m];
         end
      end
      if (!four) begin
         w[WORD_W-1:16] = '0;
      end
      return w;
   endfunction

   // value repeated in the lowest cnt bytes
   function automatic logic [WORD_W-1:0] rep_byte(input logic [CODE_W-1:0] v,
                                                  input logic [BC_W-1:0] cnt);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int m = 0; m < 4; m++) begin
         if (BC_W'(m) < cnt) begin
            w[8*m +: 8] = v;
         end
      end
      return w;
   endfunction

endpackage

// ===== rtl/pcxd_req_if.sv =====
// request channel carrying compressed bytes
interface pcxd_req_if;
   logic                        valid;
   logic                        ready;
   logic [pcxd_pkg::CODE_W-1:0] code_byte;
   logic                        start_image;

   modport source (output valid, output code_byte, output start_image, input ready);
   modport sink   (input valid, input code_byte, input start_image, output ready);
endinterface

// ===== rtl/pcxd_rsp_if.sv =====
// result channel carrying decoded words
interface pcxd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pcxd_pkg::WORD_W-1:0] data_word;
   logic [pcxd_pkg::BC_W-1:0]   byte_count;
   logic                        end_of_line;
   logic                        end_of_image;
   logic                        last;

   modport source (output valid, output data_word, output byte_count, output end_of_line,
                   output end_of_image, output last, input ready);
   modport sink   (input valid, input data_word, input byte_count, input end_of_line,
                   input end_of_image, input last, output ready);
endinterface

// ===== rtl/pcxd_line_store.sv =====
// line store: byte-wide single-port-write memory with registered read
module pcxd_line_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                          clock,
   input  pcxd_pkg::store_wr_type        wr,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [pcxd_pkg::CODE_W-1:0]   rd_data
);

   logic [pcxd_pkg::CODE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/pcx_rle_planar_to_packed_decoder_top.sv =====
// pcx run-length decoder with planar-to-packed line conversion
//
// requests enter on req_chan (valid/ready), one compressed byte each; a request
// with start_image set opens a new image. results leave on rsp_chan through an
// output register, so a stalled receiver only holds the sequencer, never drops data.
// configuration is written through csr_we/csr_index/csr_wdata; the user must write
// it only while idle, as the block itself does not enforce this. direct mode: a run
// marker is only held; a literal or run value is sent as one result of up to four
// bytes per cycle while the output slot is free. planar mode: every decoded byte is
// one write to the line store. a completed line is emitted one group at a time: each
// plane-byte group takes four reads through the single read port, whose read is
// registered, and one output load; groups past the plane width are emitted as zeros
// without reads. reset clears control state and leaves the block idle: requests are
// taken and ignored until one with start_image set arrives. the line store is not
// cleared.
module pcx_rle_planar_to_packed_decoder_top #(
   parameter int MAX_PLANE_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   pcxd_req_if.sink                          req_chan,
   pcxd_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [pcxd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pcxd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH    = 4 * MAX_PLANE_BYTES;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int PLANES_W = $clog2(MAX_PLANE_BYTES + 1);
   localparam int FILL_W   = PLANES_W + 2;
   localparam int CMP_W    = (PLANES_W > pcxd_pkg::GROUP_W) ? PLANES_W : pcxd_pkg::GROUP_W;
   localparam logic [8:0] MAX_PB = 9'(MAX_PLANE_BYTES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIRECT = 3'd1;
   localparam logic [2:0] S_FILL   = 3'd2;
   localparam logic [2:0] S_GATHER = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   // configuration
   logic                              mode_ff;
   logic [pcxd_pkg::PLB_W-1:0]        plb_ff;
   logic [pcxd_pkg::GW_W-1:0]         gw_ff;
   logic [pcxd_pkg::LINES_W-1:0]      lc_ff;
   logic [pcxd_pkg::COUNT_W-1:0]      dc_ff;

   // decoder state
   logic [2:0]                        state_ff, state_in;
   logic                              awaiting_ff, awaiting_in;
   logic [pcxd_pkg::RUN_W-1:0]        pending_ff, pending_in;
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic [pcxd_pkg::LINES_W-1:0]      lines_done_ff, lines_done_in;
   logic [pcxd_pkg::COUNT_W-1:0]      bytes_left_ff, bytes_left_in;
   logic                              image_done_ff, image_done_in;
   logic [pcxd_pkg::CODE_W-1:0]       val_ff, val_in;
   logic [pcxd_pkg::RUN_W-1:0]        run_ff, run_in;
   logic [pcxd_pkg::GW_W-1:0]         cnt_ff, cnt_in;
   logic [pcxd_pkg::GROUP_W-1:0]      g_ff, g_in;
   logic [ADDR_W-1:0]                 addr_ff, addr_in;
   logic [2:0]                        rd_idx_ff, rd_idx_in;
   logic [1:0]                        got_ff, got_in;
   logic                              rdv_ff, rdv_in;
   logic [pcxd_pkg::WORD_W-1:0]       gather_ff, gather_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pcxd_pkg::WORD_W-1:0]       rsp_word_ff, rsp_word_in;
   logic [pcxd_pkg::BC_W-1:0]         rsp_bc_ff, rsp_bc_in;
   logic                              rsp_eol_ff, rsp_eol_in;
   logic                              rsp_eoi_ff, rsp_eoi_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [8:0]                        planes_x;
   logic [PLANES_W-1:0]               planes;
   logic [FILL_W-1:0]                 len;
   logic                              g_ok;
   logic                              slot_free;
   logic                              accept;
   logic                              rd_en;
   logic [pcxd_pkg::CODE_W-1:0]       mem_q;
   pcxd_pkg::store_wr_type            wr_req;

   assign planes_x  = (plb_ff == '0) ? 9'd1 :
                      (({2'b00, plb_ff} > MAX_PB) ? MAX_PB : {2'b00, plb_ff});
   assign planes    = PLANES_W'(planes_x);
   assign len       = {planes, 2'b00};
   assign g_ok      = CMP_W'(g_ff) < CMP_W'(planes);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.data_word    = rsp_word_ff;
   assign rsp_chan.byte_count   = rsp_bc_ff;
   assign rsp_chan.end_of_line  = rsp_eol_ff;
   assign rsp_chan.end_of_image = rsp_eoi_ff;
   assign rsp_chan.last         = rsp_last_ff;

   assign rd_en = (state_ff == S_GATHER) && !rd_idx_ff[2];

   always_comb begin
      logic                           go;
      logic                           done_eff;
      logic [pcxd_pkg::CODE_W-1:0]    v;
      logic [pcxd_pkg::RUN_W-1:0]     run;
      logic [pcxd_pkg::COUNT_W-1:0]   bl;
      logic [pcxd_pkg::COUNT_W-1:0]   dc_eff;
      logic [pcxd_pkg::RUN_W-1:0]     take;
      logic [pcxd_pkg::BC_W-1:0]      c;
      logic [pcxd_pkg::GW_W-1:0]      rem_nx;
      logic [pcxd_pkg::GW_W-1:0]      gw_eff;
      logic [pcxd_pkg::LINES_W-1:0]   lines;
      logic [pcxd_pkg::LINES_W-1:0]   ld_nx;
      logic [pcxd_pkg::GROUP_W-1:0]   g_nx;
      logic                           four;

      state_in      = state_ff;
      awaiting_in   = awaiting_ff;
      pending_in    = pending_ff;
      fill_in       = fill_ff;
      lines_done_in = lines_done_ff;
      bytes_left_in = bytes_left_ff;
      image_done_in = image_done_ff;
      val_in        = val_ff;
      run_in        = run_ff;
      cnt_in        = cnt_ff;
      g_in          = g_ff;
      addr_in       = addr_ff;
      rd_idx_in     = rd_idx_ff;
      got_in        = got_ff;
      rdv_in        = rd_en;
      gather_in     = gather_ff;
      wr_req.en     = 1'b0;
      wr_req.data   = val_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in   = rsp_word_ff;
      rsp_bc_in     = rsp_bc_ff;
      rsp_eol_in    = rsp_eol_ff;
      rsp_eoi_in    = rsp_eoi_ff;
      rsp_last_in   = rsp_last_ff;

      go       = 1'b0;
      v        = req_chan.code_byte;
      run      = 6'd1;
      dc_eff   = (dc_ff == '0) ? 20'd1 : dc_ff;
      bl       = bytes_left_ff;
      take     = '0;
      c        = '0;
      rem_nx   = '0;
      gw_eff   = (gw_ff == '0) ? 9'd1 : ((gw_ff > pcxd_pkg::GW_MAX) ? pcxd_pkg::GW_MAX : gw_ff);
      lines    = (lc_ff == '0) ? 10'd1 : lc_ff;
      ld_nx    = lines_done_ff + 10'd1;
      g_nx     = g_ff + 6'd1;
      four     = cnt_ff >= 9'd4;
      done_eff = image_done_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_chan.start_image) begin
                  fill_in       = '0;
                  pending_in    = '0;
                  awaiting_in   = 1'b0;
                  lines_done_in = '0;
                  bytes_left_in = dc_eff;
                  image_done_in = 1'b0;
                  bl            = dc_eff;
                  done_eff      = 1'b0;
               end
               if (!done_eff) begin
                  if (awaiting_in) begin
                     run         = pending_in;
                     awaiting_in = 1'b0;
                     pending_in  = '0;
                     go          = 1'b1;
                  end else if (req_chan.code_byte > pcxd_pkg::RUN_BASE) begin
                     pending_in  = 6'(req_chan.code_byte - pcxd_pkg::RUN_BASE);
                     awaiting_in = 1'b1;
                  end else begin
                     go = 1'b1;
                  end
               end
               if (go) begin
                  val_in = v;
                  if (mode_ff) begin
                     take          = ({14'd0, run} < bl) ? run : bl[pcxd_pkg::RUN_W-1:0];
                     bytes_left_in = bl - {14'd0, take};
                     cnt_in        = {3'd0, take};
                     if (bytes_left_in == '0) begin
                        image_done_in = 1'b1;
                     end
                     state_in = (take != '0) ? S_DIRECT : S_IDLE;
                  end else begin
                     run_in   = run;
                     state_in = S_FILL;
                  end
               end
            end
         end

         S_DIRECT: begin
            if (slot_free) begin
               c            = four ? 3'd4 : cnt_ff[2:0];
               rem_nx       = cnt_ff - {6'd0, c};
               cnt_in       = rem_nx;
               rsp_valid_in = 1'b1;
               rsp_word_in  = pcxd_pkg::rep_byte(val_ff, c);
               rsp_bc_in    = c;
               rsp_eol_in   = 1'b0;
               rsp_eoi_in   = (rem_nx == '0) && (bytes_left_ff == '0);
               rsp_last_in  = (rem_nx == '0);
               if (rem_nx == '0) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_FILL: begin
            if ((run_ff != '0) && (fill_ff < len)) begin
               wr_req.en = 1'b1;
               fill_in   = fill_ff + 1'b1;
               run_in    = run_ff - 1'b1;
               if ((run_ff == 6'd1) && (fill_in < len)) begin
                  state_in = S_IDLE;
               end
            end else if (fill_ff >= len) begin
               // line complete: start group emission
               fill_in       = '0;
               lines_done_in = ld_nx;
               if (ld_nx >= lines) begin
                  image_done_in = 1'b1;
               end
               cnt_in    = gw_eff;
               g_in      = '0;
               addr_in   = '0;
               rd_idx_in = '0;
               got_in    = '0;
               state_in  = S_GATHER;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_GATHER: begin
            if (rd_en) begin
               addr_in   = addr_ff + ADDR_W'(planes);
               rd_idx_in = rd_idx_ff + 3'd1;
            end
            if (rdv_ff) begin
               gather_in = {mem_q, gather_ff[pcxd_pkg::WORD_W-1:8]};
               got_in    = got_ff + 2'd1;
               if (got_ff == 2'd3) begin
                  state_in = S_OUT;
               end
            end
         end

         S_OUT: begin
            if (slot_free) begin
               rem_nx       = (cnt_ff > 9'd4) ? (cnt_ff - 9'd4) : '0;
               cnt_in       = rem_nx;
               rsp_valid_in = 1'b1;
               rsp_word_in  = pcxd_pkg::pack_group(g_ok ? gather_ff : '0, four);
               rsp_bc_in    = four ? 3'd4 : 3'd2;
               rsp_eol_in   = (rem_nx == '0);
               rsp_eoi_in   = (rem_nx == '0) && image_done_ff;
               rsp_last_in  = (rem_nx == '0);
               if (rem_nx == '0) begin
                  state_in = S_IDLE;
               end else begin
                  g_in      = g_nx;
                  addr_in   = ADDR_W'(g_nx);
                  rd_idx_in = '0;
                  got_in    = '0;
                  state_in  = (CMP_W'(g_nx) < CMP_W'(planes)) ? S_GATHER : S_OUT;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         plb_ff  <= 7'd1;
         gw_ff   <= 9'd1;
         lc_ff   <= 10'd1;
         dc_ff   <= 20'd1;
      end else if (csr_we) begin
         case (csr_index)
            pcxd_pkg::CSR_DIRECT_MODE:      mode_ff <= csr_wdata[0];
            pcxd_pkg::CSR_PLANE_LINE_BYTES: plb_ff  <= csr_wdata[pcxd_pkg::PLB_W-1:0];
            pcxd_pkg::CSR_GROUP_WIDTH:      gw_ff   <= csr_wdata[pcxd_pkg::GW_W-1:0];
            pcxd_pkg::CSR_LINE_COUNT:       lc_ff   <= csr_wdata[pcxd_pkg::LINES_W-1:0];
            pcxd_pkg::CSR_DIRECT_COUNT:     dc_ff   <= csr_wdata[pcxd_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         awaiting_ff   <= 1'b0;
         pending_ff    <= '0;
         fill_ff       <= '0;
         lines_done_ff <= '0;
         bytes_left_ff <= '0;
         image_done_ff <= 1'b1;
         run_ff        <= '0;
         cnt_ff        <= '0;
         g_ff          <= '0;
         rd_idx_ff     <= '0;
         got_ff        <= '0;
         rdv_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         awaiting_ff   <= awaiting_in;
         pending_ff    <= pending_in;
         fill_ff       <= fill_in;
         lines_done_ff <= lines_done_in;
         bytes_left_ff <= bytes_left_in;
         image_done_ff <= image_done_in;
         run_ff        <= run_in;
         cnt_ff        <= cnt_in;
         g_ff          <= g_in;
         rd_idx_ff     <= rd_idx_in;
         got_ff        <= got_in;
         rdv_ff        <= rdv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      addr_ff     <= addr_in;
      gather_ff   <= gather_in;
      rsp_word_ff <= rsp_word_in;
      rsp_bc_ff   <= rsp_bc_in;
      rsp_eol_ff  <= rsp_eol_in;
      rsp_eoi_ff  <= rsp_eoi_in;
      rsp_last_ff <= rsp_last_in;
   end

   pcxd_line_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .wr      (wr_req),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_q)
   );

endmodule

// ===== rtl/pcxd_checker.sv =====
// port-level checker for the pcx decoder and its bind to the top level
`include "assert_macros.svh"

module pcxd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [pcxd_pkg::WORD_W-1:0]     rsp_data_word,
   input logic [pcxd_pkg::BC_W-1:0]       rsp_byte_count,
   input logic                            rsp_end_of_line,
   input logic                            rsp_end_of_image,
   input logic                            rsp_last
);

   // image end always closes the request's results
   `PCXD_ASSERT_NOW(a_eoi_last, clock, reset, rsp_valid && rsp_end_of_image, rsp_last, "end of image without last")

   // a planar line ends on the last result of a request, with two or four bytes
   `PCXD_ASSERT_NOW(a_eol_last, clock, reset, rsp_valid && rsp_end_of_line, rsp_last && (rsp_byte_count == 3'd2 || rsp_byte_count == 3'd4), "bad end of line")

   // byte count in range and unused bytes zero
   `PCXD_ASSERT_NOW(a_count_bytes, clock, reset, rsp_valid, (rsp_byte_count == 3'd4) || (rsp_byte_count == 3'd3 && rsp_data_word[31:24] == 8'd0) || (rsp_byte_count == 3'd2 && rsp_data_word[31:16] == 16'd0) || (rsp_byte_count == 3'd1 && rsp_data_word[31:8] == 24'd0), "byte count and data disagree")

   // stalled result holds
   `PCXD_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_word) && $stable(rsp_last), "stalled result changed")

endmodule

bind pcx_rle_planar_to_packed_decoder_top pcxd_checker u_pcxd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_data_word    (rsp_chan.data_word),
   .rsp_byte_count   (rsp_chan.byte_count),
   .rsp_end_of_line  (rsp_chan.end_of_line),
   .rsp_end_of_image (rsp_chan.end_of_image),
   .rsp_last         (rsp_chan.last)
);

// ===== dv/pcxd_decode_checker.sv =====
// result checker for the pcx run-length decoder: watches the channels, predicts and compares
module pcxd_decode_checker (
   input  logic                            clock,
   input  logic                            reset,
   pcxd_req_if                             req_mon,
   pcxd_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [pcxd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcxd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              words_owed,
   output logic                            image_open
);

   localparam int PLANE_CAP = 64;
   localparam int ROW_CAP   = 4 * PLANE_CAP;

   typedef struct packed {
      logic [pcxd_pkg::WORD_W-1:0] data_word;
      logic [pcxd_pkg::BC_W-1:0]   byte_count;
      logic                        end_of_line;
      logic                        end_of_image;
      logic                        last;
   } decoded_word_type;

   decoded_word_type owed_q[$];
   decoded_word_type batch_q[$];

   logic                             cfg_direct;
   logic [pcxd_pkg::PLB_W-1:0]       cfg_plane_bytes;
   logic [pcxd_pkg::GW_W-1:0]        cfg_group_width;
   logic [pcxd_pkg::LINES_W-1:0]     cfg_rows;
   logic [pcxd_pkg::COUNT_W-1:0]     cfg_direct_total;

   logic [pcxd_pkg::CODE_W-1:0]      row_bytes [ROW_CAP];
   int unsigned                      fill_level;
   int unsigned                      repeat_len;
   logic                             value_due;
   logic [pcxd_pkg::LINES_W-1:0]     rows_done;
   int unsigned                      direct_left;
   logic                             image_idle;

   task automatic pack_row(input int unsigned planes, input logic eoi);
      int unsigned                 rem;
      int unsigned                 g;
      int unsigned                 nbytes;
      logic [pcxd_pkg::CODE_W-1:0] pb [4];
      logic [pcxd_pkg::WORD_W-1:0] w;
      decoded_word_type            item;
      rem = (cfg_group_width == 0) ? 1 : ((cfg_group_width > 256) ? 256 : cfg_group_width);
      g = 0;
      while (rem > 0) begin
         nbytes = (rem >= 4) ? 4 : 2;
         for (int p = 0; p < 4; p++) begin
            pb[p] = (g < planes) ? row_bytes[p * planes + g] : '0;
         end
         w = '0;
         for (int m = 0; m < nbytes; m++) begin
            for (int p = 0; p < 4; p++) begin
               w[8*m + p]     = pb[p][7 - 2*m];
               w[8*m + 4 + p] = pb[p][6 - 2*m];
            end
         end
         rem = (rem > 4) ? rem - 4 : 0;
         item.data_word    = w;
         item.byte_count   = 3'(nbytes);
         item.end_of_line  = (rem == 0);
         item.end_of_image = (rem == 0) ? eoi : 1'b0;
         item.last         = 1'b0;
         batch_q.push_back(item);
         g++;
      end
   endtask

   task automatic decode_request(input logic [pcxd_pkg::CODE_W-1:0] code, input logic start);
      int unsigned                 val;
      int unsigned                 run;
      int unsigned                 take;
      int unsigned                 cnt;
      int unsigned                 planes;
      int unsigned                 rows;
      logic [pcxd_pkg::WORD_W-1:0] w;
      decoded_word_type            item;
      batch_q.delete();
      if (start) begin
         fill_level  = 0;
         repeat_len  = 0;
         value_due   = 1'b0;
         rows_done   = '0;
         direct_left = (cfg_direct_total == 0) ? 1 : cfg_direct_total;
         image_idle  = 1'b0;
      end
      if (image_idle) return;
      if (value_due) begin
         val        = code;
         run        = repeat_len;
         value_due  = 1'b0;
         repeat_len = 0;
      end else if (code > pcxd_pkg::RUN_BASE) begin
         repeat_len = code - pcxd_pkg::RUN_BASE;
         value_due  = 1'b1;
         return;
      end else begin
         val = code;
         run = 1;
      end
      if (cfg_direct) begin
         take = (run < direct_left) ? run : direct_left;
         direct_left -= take;
         while (take > 0) begin
            cnt = (take < 4) ? take : 4;
            w = '0;
            for (int m = 0; m < cnt; m++) begin
               w[8*m +: 8] = val[7:0];
            end
            take -= cnt;
            item.data_word    = w;
            item.byte_count   = 3'(cnt);
            item.end_of_line  = 1'b0;
            item.end_of_image = (take == 0 && direct_left == 0);
            item.last         = 1'b0;
            batch_q.push_back(item);
         end
         if (direct_left == 0) image_idle = 1'b1;
      end else begin
         planes = (cfg_plane_bytes == 0) ? 1 :
                  ((cfg_plane_bytes > PLANE_CAP) ? PLANE_CAP : cfg_plane_bytes);
         rows = (cfg_rows == 0) ? 1 : cfg_rows;
         while (run > 0 && fill_level < 4 * planes) begin
            row_bytes[fill_level] = val[7:0];
            fill_level++;
            run--;
         end
         if (fill_level >= 4 * planes) begin
            fill_level = 0;
            rows_done  = rows_done + 1'b1;
            if (rows_done >= rows) image_idle = 1'b1;
            pack_row(planes, image_idle);
         end
      end
      if (batch_q.size() > 0) begin
         item = batch_q.pop_back();
         item.last = 1'b1;
         batch_q.push_back(item);
      end
      foreach (batch_q[i]) owed_q.push_back(batch_q[i]);
   endtask

   always @(posedge clock) begin
      decoded_word_type seen;
      decoded_word_type want;
      if (reset) begin
         cfg_direct       = 1'b0;
         cfg_plane_bytes  = 7'd1;
         cfg_group_width  = 9'd1;
         cfg_rows         = 10'd1;
         cfg_direct_total = 20'd1;
         fill_level       = 0;
         repeat_len       = 0;
         value_due        = 1'b0;
         rows_done        = '0;
         direct_left      = 0;
         image_idle       = 1'b1;
         fail_count       = 0;
         owed_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.data_word    = rsp_mon.data_word;
            seen.byte_count   = rsp_mon.byte_count;
            seen.end_of_line  = rsp_mon.end_of_line;
            seen.end_of_image = rsp_mon.end_of_image;
            seen.last         = rsp_mon.last;
            if (owed_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected result: word %h count %0d eol %b eoi %b last %b",
                           seen.data_word, seen.byte_count, seen.end_of_line,
                           seen.end_of_image, seen.last);
               end
               fail_count++;
            end else begin
               want = owed_q.pop_front();
               if (seen !== want) begin
                  if (fail_count < 10) begin
                     $display("mismatch: expected word %h count %0d eol %b eoi %b last %b",
                              want.data_word, want.byte_count, want.end_of_line,
                              want.end_of_image, want.last);
                     $display("          got      word %h count %0d eol %b eoi %b last %b",
                              seen.data_word, seen.byte_count, seen.end_of_line,
                              seen.end_of_image, seen.last);
                  end
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               pcxd_pkg::CSR_DIRECT_MODE:
                  cfg_direct       = csr_wdata[0];
               pcxd_pkg::CSR_PLANE_LINE_BYTES:
                  cfg_plane_bytes  = csr_wdata[pcxd_pkg::PLB_W-1:0];
               pcxd_pkg::CSR_GROUP_WIDTH:
                  cfg_group_width  = csr_wdata[pcxd_pkg::GW_W-1:0];
               pcxd_pkg::CSR_LINE_COUNT:
                  cfg_rows         = csr_wdata[pcxd_pkg::LINES_W-1:0];
               pcxd_pkg::CSR_DIRECT_COUNT:
                  cfg_direct_total = csr_wdata[pcxd_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            decode_request(req_mon.code_byte, req_mon.start_image);
         end
      end
      words_owed <= owed_q.size();
      image_open <= !image_idle;
   end

endmodule

// ===== dv/pcx_rle_planar_to_packed_decoder_top_tb.sv =====
// testbench top for the pcx run-length decoder: clock, reset, stimulus and verdict
module pcx_rle_planar_to_packed_decoder_top_tb;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [pcxd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pcxd_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                              fail_count;
   int                              words_owed;
   logic                            image_open;
   int                              send_gap_pct = 22;
   int                              rsp_hold_pct = 64;

   pcxd_req_if req_chan ();
   pcxd_rsp_if rsp_chan ();

   pcx_rle_planar_to_packed_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pcxd_decode_checker u_decode_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .words_owed (words_owed),
      .image_open (image_open)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_hold_pct);
   end

   task automatic send_request(input logic [pcxd_pkg::CODE_W-1:0] code, input logic start);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.code_byte   <= code;
      req_chan.start_image <= start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // drain outstanding words, then give a run in flight time to finish
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pcxd_pkg::CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 20'(val);
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned direct, input int unsigned plane_bytes,
                            input int unsigned group_width, input int unsigned rows,
                            input int unsigned direct_total);
      settle();
      write_reg(pcxd_pkg::CSR_DIRECT_MODE, direct);
      write_reg(pcxd_pkg::CSR_PLANE_LINE_BYTES, plane_bytes);
      write_reg(pcxd_pkg::CSR_GROUP_WIDTH, group_width);
      write_reg(pcxd_pkg::CSR_LINE_COUNT, rows);
      write_reg(pcxd_pkg::CSR_DIRECT_COUNT, direct_total);
      csr_we <= 1'b0;
   endtask

   task automatic run_traffic(input int n);
      int   sent;
      int   pick;
      logic fresh;
      sent  = 0;
      fresh = 1'b0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 4 || (!image_open && !fresh)) begin
            send_request(8'($urandom_range(255)), 1'b1);
            fresh = 1'b1;
         end else if (pick < 30) begin
            // run marker then value, now and then cut short by a new image
            send_request(8'($urandom_range(255, 193)), 1'b0);
            send_request(8'($urandom_range(255)), pick < 7);
            fresh = (pick < 7);
            sent++;
         end else begin
            send_request(8'($urandom_range(192)), 1'b0);
            fresh = 1'b0;
         end
         sent++;
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.code_byte   = '0;
      req_chan.start_image = 1'b0;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // idle after reset, then one line on the reset settings
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h3C, 1'b1);
      send_request(8'hC3, 1'b0);
      send_request(8'hE1, 1'b0);

      // partial group past the plane width, run that fills the last line of the image
      configure(0, 1, 5, 2, 1);
      send_request(8'hC1, 1'b1);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hC0, 1'b0);
      send_request(8'hAA, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hC3, 1'b0);
      send_request(8'h12, 1'b0);

      // direct bytes, clipped run, new image while a run value is due
      configure(1, 1, 1, 1, 5);
      send_request(8'h01, 1'b1);
      send_request(8'hC7, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'hC5, 1'b1);
      send_request(8'h33, 1'b1);
      send_request(8'hC2, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hC0, 1'b0);
      send_request(8'h7F, 1'b0);

      configure(0, 1, 4, 3, 1);
      run_traffic(25);
      configure(0, 2, 8, 2, 1);
      run_traffic(25);
      configure(0, 0, 0, 0, 0);
      run_traffic(15);
      configure(1, 1, 1, 1, 37);
      run_traffic(30);

      send_gap_pct = 64;
      rsp_hold_pct = 22;
      configure(1, 1, 1, 1, 0);
      run_traffic(15);
      configure(0, 3, 14, 2, 1);
      run_traffic(20);
      configure(0, 64, 256, 1, 1);
      run_traffic(15);
      configure(0, 127, 511, 1023, 1);
      run_traffic(15);

      send_gap_pct = 0;
      rsp_hold_pct = 0;
      configure(1, 1, 1, 1, 524288);
      run_traffic(15);
      configure(1, 64, 256, 512, 1048575);
      run_traffic(15);
      configure(0, 1, 1, 512, 1);
      run_traffic(25);
      configure(0, $urandom_range(8, 1), $urandom_range(40, 1), $urandom_range(4, 1),
                $urandom_range(64, 1));
      run_traffic(30);
      configure(1, $urandom_range(8, 1), $urandom_range(40, 1), $urandom_range(4, 1),
                $urandom_range(64, 1));
      run_traffic(30);

      settle();
      if (fail_count == 0 && words_owed == 0) begin
         $display("PASS pcx_rle_planar_to_packed_decoder_top");
      end else begin
         $display("FAIL pcx_rle_planar_to_packed_decoder_top");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("FAIL pcx_rle_planar_to_packed_decoder_top");
      $finish;
   end

endmodule
